>>> sv/assert_macros.svh
// Assertion macros shared by the sorted priority queue RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// expression must hold at every edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: invariant");
// trigger in one cycle implies the consequence in the next
`define ASSERT_NEXT(lbl, clk, rst, trig, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_NEXT(lbl, clk, rst, trig, cons)
`endif
`endif

>>> sv/spq_pkg.sv
// Package for the sorted priority queue: sizes, codes, controller types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package spq_pkg;

   // queue depth, the count width derived from it, and field widths
   localparam int DEPTH  = 8;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int NAME_W = 64;
   localparam int PRIO_W = 16;
   localparam int STAT_W = 2;
   localparam int OCC_W  = 4;

   // request modes
   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_SERVE  = 1'b1;

   // result status codes
   localparam logic [STAT_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP,
      ST_PEND
   } spq_state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load_req;
      logic exec;
   } spq_cmd_type;

   // datapath status
   typedef struct packed {
      logic [CNT_W-1:0] count;
   } spq_stat_type;

endpackage

>>> sv/spq_ctrl.sv
// Controller for the sorted priority queue: request/response sequencing.
// Depends on spq_pkg for the state and command types.
`timescale 1ns / 1ps
module spq_ctrl import spq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output spq_cmd_type cmd
);

   spq_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            // a new word may be taken while the result still waits
            if (req_valid && rsp_ready) state_in = ST_EXEC;
            else if (req_valid)         state_in = ST_PEND;
            else if (rsp_ready)         state_in = ST_IDLE;
         end
         ST_PEND: begin
            if (rsp_ready) state_in = ST_EXEC;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      cmd.exec     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         ST_RESP: begin
            req_ready = 1'b1;
            rsp_valid = 1'b1;
         end
         ST_PEND: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      cmd.load_req = req_ready & req_valid;
   end

endmodule

>>> sv/spq_datapath.sv
// Datapath for the sorted priority queue: request register, row of sorted
// entry cells with parallel compare and shift, result register. Uses spq_pkg.
`timescale 1ns / 1ps
module spq_datapath import spq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  spq_cmd_type       cmd,
   output spq_stat_type      stat,
   input  logic              req_mode,
   input  logic [NAME_W-1:0] req_name_chars,
   input  logic [PRIO_W-1:0] req_priority_req,
   output logic [NAME_W-1:0] rsp_served_name,
   output logic [PRIO_W-1:0] rsp_served_priority,
   output logic [STAT_W-1:0] rsp_status,
   output logic [OCC_W-1:0]  rsp_occupancy
);

   // captured request word
   logic              mode_ff;
   logic [NAME_W-1:0] name_ff;
   logic [PRIO_W-1:0] prio_ff;

   // entry cells, head at index 0
   logic [PRIO_W-1:0] cell_prio_ff [DEPTH];
   logic [NAME_W-1:0] cell_name_ff [DEPTH];
   logic [PRIO_W-1:0] cell_prio_in [DEPTH];
   logic [NAME_W-1:0] cell_name_in [DEPTH];
   logic [CNT_W-1:0]  count_ff, count_in;

   // neighbor taps
   logic [DEPTH-1:0]  gt;
   logic [DEPTH-1:0]  dn_gt;
   logic [PRIO_W-1:0] dn_prio [DEPTH];
   logic [NAME_W-1:0] dn_name [DEPTH];
   logic [PRIO_W-1:0] up_prio [DEPTH];
   logic [NAME_W-1:0] up_name [DEPTH];

   // result registers
   logic [NAME_W-1:0] res_name_ff;
   logic [PRIO_W-1:0] res_prio_ff;
   logic [STAT_W-1:0] res_stat_ff;
   logic [OCC_W-1:0]  res_occ_ff;

   logic full, empty, do_insert, do_serve;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);
   assign do_insert = cmd.exec && (mode_ff == MODE_INSERT) && !full;
   assign do_serve  = cmd.exec && (mode_ff == MODE_SERVE) && !empty;

   // per cell: does the new entry go at or before this cell
   // (unused cells count as greater, so an append lands at the tail)
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      assign gt[i] = (CNT_W'(i) >= count_ff) || (cell_prio_ff[i] > prio_ff);
      if (i == 0) begin : g_head
         assign dn_gt[i]   = 1'b0;
         assign dn_prio[i] = prio_ff;
         assign dn_name[i] = name_ff;
      end else begin : g_body
         assign dn_gt[i]   = gt[i-1];
         assign dn_prio[i] = cell_prio_ff[i-1];
         assign dn_name[i] = cell_name_ff[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign up_prio[i] = cell_prio_ff[i];
         assign up_name[i] = cell_name_ff[i];
      end else begin : g_inner
         assign up_prio[i] = cell_prio_ff[i+1];
         assign up_name[i] = cell_name_ff[i+1];
      end
   end

   // next cell contents: insert shifts the tail up, serve shifts all down
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cell_prio_in[i] = cell_prio_ff[i];
         cell_name_in[i] = cell_name_ff[i];
         if (do_insert && gt[i]) begin
            if (dn_gt[i]) begin
               cell_prio_in[i] = dn_prio[i];
               cell_name_in[i] = dn_name[i];
            end else begin
               cell_prio_in[i] = prio_ff;
               cell_name_in[i] = name_ff;
            end
         end else if (do_serve) begin
            cell_prio_in[i] = up_prio[i];
            cell_name_in[i] = up_name[i];
         end
      end
   end

   // entry count
   always_comb begin
      count_in = count_ff;
      if (do_insert)     count_in = count_ff + CNT_W'(1);
      else if (do_serve) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         mode_ff <= req_mode;
         name_ff <= req_name_chars;
         prio_ff <= req_priority_req;
      end
      for (int i = 0; i < DEPTH; i++) begin
         cell_prio_ff[i] <= cell_prio_in[i];
         cell_name_ff[i] <= cell_name_in[i];
      end
      if (cmd.exec) begin
         res_occ_ff  <= OCC_W'(count_in);
         res_name_ff <= '0;
         res_prio_ff <= '0;
         res_stat_ff <= STATUS_DONE;
         if (mode_ff == MODE_INSERT) begin
            if (full) res_stat_ff <= STATUS_FULL;
         end else if (empty) begin
            res_stat_ff <= STATUS_EMPTY;
         end else begin
            res_name_ff <= cell_name_ff[0];
            res_prio_ff <= cell_prio_ff[0];
         end
      end
   end

   assign stat.count          = count_ff;
   assign rsp_served_name     = res_name_ff;
   assign rsp_served_priority = res_prio_ff;
   assign rsp_status          = res_stat_ff;
   assign rsp_occupancy       = res_occ_ff;

endmodule

>>> sv/sorted_priority_queue_unit.sv
// Sorted priority queue: insert keeps ascending priority (ties in arrival
// order), serve pops the head. The result word is registered in the
// execute state, in which all cells compare and shift in parallel; the next
// word can be taken while the last result still waits, but not in execution.
// Reset clears the controller and the entry count; cells need no clearing.
// Depends on spq_pkg, spq_ctrl, spq_datapath and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sorted_priority_queue_unit import spq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_mode,
   input  logic [NAME_W-1:0] req_name_chars,
   input  logic [PRIO_W-1:0] req_priority_req,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [NAME_W-1:0] rsp_served_name,
   output logic [PRIO_W-1:0] rsp_served_priority,
   output logic [STAT_W-1:0] rsp_status,
   output logic [OCC_W-1:0]  rsp_occupancy
);

   spq_cmd_type  cmd;
   spq_stat_type stat;
   logic         rsp_failed;
   logic         rsp_data_zero;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   spq_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_mode            (req_mode),
      .req_name_chars      (req_name_chars),
      .req_priority_req    (req_priority_req),
      .rsp_served_name     (rsp_served_name),
      .rsp_served_priority (rsp_served_priority),
      .rsp_status          (rsp_status),
      .rsp_occupancy       (rsp_occupancy)
   );

   // result word flags for the checks below
   assign rsp_failed    = rsp_valid && (rsp_status != STATUS_DONE);
   assign rsp_data_zero = (rsp_served_name == '0) && (rsp_served_priority == '0);

   // entry count never passes the depth
   `ASSERT_ALWAYS(a_count_bound, clock, reset, stat.count <= CNT_W'(DEPTH))
   // an accepted word blocks the next one until it has executed
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)
   // execution always produces a result word in the next cycle
   `ASSERT_NEXT(a_exec_result, clock, reset, cmd.exec, rsp_valid)
   // failed requests return no entry data
   `ASSERT_ALWAYS(a_fail_zero, clock, reset, !rsp_failed || rsp_data_zero)

endmodule

>>> tb/sorted_priority_queue_unit_tb.sv
// Self-checking bench for sorted_priority_queue_unit: directed and random insert/serve words,
// with a scoreboard class that keeps its own sorted copy of the queue.
// Depends on spq_pkg and the sorted_priority_queue_unit RTL.
`timescale 1ns / 1ps
module sorted_priority_queue_unit_tb;
   import spq_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_WORDS  = 1300;
   localparam int DRAIN_CYCLES  = 20;
   localparam int STALL_CYCLES  = 80;
   localparam int STALL_TRIGGER = 200;

   // one held entry of the queue
   typedef struct {
      logic [NAME_W-1:0] name;
      logic [PRIO_W-1:0] prio;
   } queue_entry_type;

   // one expected result word
   typedef struct {
      logic [NAME_W-1:0] name;
      logic [PRIO_W-1:0] prio;
      logic [STAT_W-1:0] status;
      logic [OCC_W-1:0]  occ;
   } served_word_type;

   // Scoreboard: mirrors the sorted store and queues the words it predicts.
   class queue_scoreboard;
      queue_entry_type held[$];
      served_word_type pending_words[$];
      int              errors;

      function new();
         errors = 0;
      endfunction

      function int pending();
         return pending_words.size();
      endfunction

      function void note_request(logic mode, logic [NAME_W-1:0] name,
                                 logic [PRIO_W-1:0] prio);
         served_word_type w;
         queue_entry_type e;
         int              pos;
         w.name   = '0;
         w.prio   = '0;
         w.status = STATUS_DONE;
         if (mode == MODE_INSERT) begin
            if (held.size() >= DEPTH) begin
               w.status = STATUS_FULL;
            end else begin
               // goes behind every entry of equal or lower priority
               pos = 0;
               while (pos < held.size() && held[pos].prio <= prio) pos++;
               e.name = name;
               e.prio = prio;
               held.insert(pos, e);
            end
         end else begin
            if (held.size() == 0) begin
               w.status = STATUS_EMPTY;
            end else begin
               e = held.pop_front();
               w.name = e.name;
               w.prio = e.prio;
            end
         end
         w.occ = OCC_W'(held.size());
         pending_words.push_back(w);
      endfunction

      function void check_result(logic [NAME_W-1:0] name, logic [PRIO_W-1:0] prio,
                                 logic [STAT_W-1:0] status, logic [OCC_W-1:0] occ);
         served_word_type w;
         if (pending_words.size() == 0) begin
            $error("result word with no request outstanding");
            errors++;
            return;
         end
         w = pending_words.pop_front();
         if (name !== w.name) begin
            $error("served_name expected %h actual %h", w.name, name);
            errors++;
         end
         if (prio !== w.prio) begin
            $error("served_priority expected %h actual %h", w.prio, prio);
            errors++;
         end
         if (status !== w.status) begin
            $error("status expected %0d actual %0d", w.status, status);
            errors++;
         end
         if (occ !== w.occ) begin
            $error("occupancy expected %0d actual %0d", w.occ, occ);
            errors++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_mode = MODE_INSERT;
   logic [NAME_W-1:0] req_name_chars = '0;
   logic [PRIO_W-1:0] req_priority_req = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [NAME_W-1:0] rsp_served_name;
   logic [PRIO_W-1:0] rsp_served_priority;
   logic [STAT_W-1:0] rsp_status;
   logic [OCC_W-1:0]  rsp_occupancy;

   queue_scoreboard sb = new();
   int              cycles = 0;
   int              words_sent = 0;
   bit              sender_no_idle = 1'b0;

   sorted_priority_queue_unit uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_name_chars      (req_name_chars),
      .req_priority_req    (req_priority_req),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_served_name     (rsp_served_name),
      .rsp_served_priority (rsp_served_priority),
      .rsp_status          (rsp_status),
      .rsp_occupancy       (rsp_occupancy)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // cycle count and timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("** sorted_priority_queue_unit: FAILED **");
         $finish;
      end
   end

   // Offer one request word; returns at the edge where it is taken.
   task automatic send_word(logic mode, logic [NAME_W-1:0] name, logic [PRIO_W-1:0] prio);
      if (!sender_no_idle) begin
         while ($urandom_range(99) < 26) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_name_chars   <= name;
      req_priority_req <= prio;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(mode, name, prio);
      words_sent++;
   endtask

   // random name: mostly full random, with the all-zero and all-one corners
   function automatic logic [NAME_W-1:0] random_name();
      int pick;
      pick = $urandom_range(19);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return {$urandom(), $urandom()};
   endfunction

   // random priority: narrow range for ties, corners, or full range
   function automatic logic [PRIO_W-1:0] random_prio();
      int pick;
      pick = $urandom_range(99);
      if (pick < 45) return PRIO_W'($urandom_range(7));
      if (pick < 50) return '0;
      if (pick < 55) return '1;
      return PRIO_W'($urandom());
   endfunction

   // Directed words: empty serve, extremes, ties, fill to full, reject, drain.
   task automatic run_directed();
      send_word(MODE_SERVE,  64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);  // serve on empty
      send_word(MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
      send_word(MODE_INSERT, 64'h0,                   16'h0000);
      send_word(MODE_INSERT, 64'h414C_4943_4500_0000, 16'd5);     // "ALICE"
      send_word(MODE_INSERT, 64'h424F_4200_0000_0000, 16'd5);     // "BOB", tie
      send_word(MODE_INSERT, 64'h4341_524F_4C00_0000, 16'd5);     // "CAROL", tie
      send_word(MODE_INSERT, 64'h4441_5645_0000_0000, 16'd3);     // "DAVE"
      send_word(MODE_INSERT, 64'h4556_4500_0000_0000, 16'hFFFF);  // "EVE", tie at top
      send_word(MODE_INSERT, 64'h4652_414E_4B00_0000, 16'd1);     // "FRANK", queue now full
      send_word(MODE_INSERT, 64'h5A5A_5A5A_5A5A_5A5A, 16'h0000);  // rejected, full
      for (int i = 0; i < DEPTH; i++) begin
         send_word(MODE_SERVE, {$urandom(), $urandom()}, PRIO_W'($urandom()));
      end
      send_word(MODE_SERVE,  64'h0, 16'h0);                       // empty again
      send_word(MODE_INSERT, 64'h8000_0000_0000_0001, 16'h8000);
      send_word(MODE_INSERT, 64'h7FFF_FFFF_FFFF_FFFE, 16'h7FFF);
      send_word(MODE_SERVE,  64'h0, 16'h0);
      send_word(MODE_SERVE,  64'h0, 16'h0);
   endtask

   // Random words: alternating fill and drain phases reach full and empty often.
   task automatic run_random();
      bit filling;
      int phase_left;
      int pct;
      filling    = 1'b1;
      phase_left = 0;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (phase_left == 0) begin
            filling    = ~filling;
            phase_left = $urandom_range(40, 8);
         end
         phase_left--;
         sender_no_idle = (n >= 400 && n < 600);
         pct = filling ? 75 : 25;
         if ($urandom_range(99) < pct) begin
            send_word(MODE_INSERT, random_name(), random_prio());
         end else begin
            send_word(MODE_SERVE, random_name(), PRIO_W'($urandom()));
         end
      end
      sender_no_idle = 1'b0;
   endtask

   // Result side: check taken words, random back-pressure, a stretch with none, one long hold-off.
   initial begin
      int  stall_left;
      bit  stall_done;
      stall_left = 0;
      stall_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            sb.check_result(rsp_served_name, rsp_served_priority, rsp_status, rsp_occupancy);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!stall_done && words_sent >= STALL_TRIGGER) begin
            // long hold-off so the block fills and stalls its input
            stall_done = 1'b1;
            stall_left = STALL_CYCLES;
            rsp_ready <= 1'b0;
         end else if (cycles >= 2000 && cycles < 4000) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 26);
         end
      end
   end

   // Main sequence
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("** sorted_priority_queue_unit: PASSED **");
      end else begin
         $display("** sorted_priority_queue_unit: FAILED **");
      end
      $finish;
   end

endmodule
